@@ src/drba_pkg.sv @@
package drba_pkg;

  localparam int BLOCK_COUNT_DEF = 64;
  localparam int MAX_RESULTS     = 64;
  localparam int CNT_W           = 13;
  localparam int START_W         = 6;
  localparam int LEN_W           = 7;
  localparam int OUTCOME_W       = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [OUTCOME_W-1:0] OUT_CLAIMED = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_SKIPPED = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_BUSY    = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_INVALID = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_MARKED  = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_SHORT   = 3'd5;

  localparam logic [1:0] KIND_MARK    = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } req_t;

endpackage

@@ src/drba_front.sv @@
module drba_front
  import drba_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic               op,
  input  logic [START_W-1:0] start,
  input  logic [LEN_W-1:0]   len,
  output req_t               req
);

  logic [CNT_W-1:0] start_ext;
  logic [CNT_W-1:0] end_ext;
  logic             start_bad;
  logic             alloc_bad;

  assign start_ext = CNT_W'(start);
  assign end_ext   = start_ext + CNT_W'(len);
  assign start_bad = start_ext >= CNT_W'(BLOCK_COUNT);
  assign alloc_bad = start_bad || (len == '0) || (end_ext > CNT_W'(BLOCK_COUNT));

  always_comb begin
    req.start = start;
    req.len   = len;
    if (!op) begin
      req.kind = start_bad ? KIND_INVALID : KIND_MARK;
    end else begin
      req.kind = alloc_bad ? KIND_INVALID : KIND_ALLOC;
    end
  end

endmodule

@@ src/drba_fifo.sv @@
module drba_fifo
  import drba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic empty,
  output req_t pop_req
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  req_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full    = count_r == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign pop_req = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

@@ src/drba_back.sv @@
module drba_back
  import drba_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  req_t                 q_req,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [START_W-1:0]   out_index,
  output logic [OUTCOME_W-1:0] out_outcome,
  output logic                 out_last
);

  localparam int MAP_AW = $clog2(BLOCK_COUNT);
  localparam int POS_W  = $clog2(BLOCK_COUNT + 1);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic                 map_mem_r [BLOCK_COUNT];
  logic                 used_r;
  logic [1:0]           state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     claimed_r, claimed_nxt;
  logic [LEN_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [START_W-1:0]   out_index_r, out_index_nxt;
  logic [OUTCOME_W-1:0] out_outcome_r, out_outcome_nxt;
  logic                 out_last_r, out_last_nxt;

  logic              advance;
  logic [POS_W-1:0]  start_ext;
  logic [POS_W-1:0]  pos_inc;
  logic              at_end;
  logic              used;
  logic [LEN_W-1:0]  claimed_inc;
  logic              done;
  logic [POS_W-1:0]  rd_pos;
  logic [MAP_AW-1:0] map_raddr;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic              map_wdata;

  assign advance     = !out_valid_r || out_ready;
  assign q_pop       = (state_r == ST_IDLE) && !q_empty && advance;
  assign start_ext   = POS_W'(q_req.start);
  assign pos_inc     = pos_r + 1'b1;
  assign at_end      = CNT_W'(pos_inc) >= CNT_W'(BLOCK_COUNT);
  assign used        = used_r;
  assign claimed_inc = claimed_r + LEN_W'(!used);
  assign done        = (claimed_inc == len_r)
                    || at_end
                    || (count_r + 1'b1 == LEN_W'(MAX_RESULTS));

  assign rd_pos    = (state_r == ST_IDLE) ? start_ext : (advance ? pos_inc : pos_r);
  assign map_raddr = rd_pos[MAP_AW-1:0];

  assign out_valid   = out_valid_r;
  assign out_index   = out_index_r;
  assign out_outcome = out_outcome_r;
  assign out_last    = out_last_r;

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    len_nxt         = len_r;
    claimed_nxt     = claimed_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_index_nxt   = out_index_r;
    out_outcome_nxt = out_outcome_r;
    out_last_nxt    = out_last_r;
    map_we          = 1'b0;
    map_waddr       = pos_r[MAP_AW-1:0];
    map_wdata       = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_wdata = 1'b0;
        if (at_end) begin
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          case (q_req.kind)
            KIND_MARK: begin
              map_we          = 1'b1;
              map_waddr       = start_ext[MAP_AW-1:0];
              out_valid_nxt   = 1'b1;
              out_index_nxt   = q_req.start;
              out_outcome_nxt = OUT_MARKED;
              out_last_nxt    = 1'b1;
            end
            KIND_ALLOC: begin
              state_nxt   = ST_WALK;
              pos_nxt     = start_ext;
              len_nxt     = q_req.len;
              claimed_nxt = '0;
              count_nxt   = '0;
            end
            default: begin
              out_valid_nxt   = 1'b1;
              out_index_nxt   = q_req.start;
              out_outcome_nxt = OUT_INVALID;
              out_last_nxt    = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = pos_r[START_W-1:0];
          if (count_r == '0 && used) begin
            out_outcome_nxt = OUT_BUSY;
            out_last_nxt    = 1'b1;
            state_nxt       = ST_IDLE;
          end else begin
            map_we          = 1'b1;
            claimed_nxt     = claimed_inc;
            out_outcome_nxt = used ? OUT_SKIPPED : OUT_CLAIMED;
            out_last_nxt    = done;
            if (done) begin
              state_nxt = ST_IDLE;
              if (claimed_inc != len_r) begin
                out_outcome_nxt = OUT_SHORT;
              end
            end else begin
              pos_nxt   = pos_inc;
              count_nxt = count_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem_r[map_waddr] <= map_wdata;
    end
    used_r <= map_mem_r[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r         <= len_nxt;
    claimed_r     <= claimed_nxt;
    count_r       <= count_nxt;
    out_index_r   <= out_index_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_last_r    <= out_last_nxt;
  end

  a_walk_not_met: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> claimed_r < len_r)
    else $error("walk continues after request length met");

  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> count_r < LEN_W'(MAX_RESULTS))
    else $error("walk exceeds result limit");

  a_walk_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> CNT_W'(pos_r) < CNT_W'(BLOCK_COUNT))
    else $error("walk position beyond disk");

  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> state_r == ST_WALK)
    else $error("non-final result while walk idle");

endmodule

@@ src/disk_block_run_allocator.sv @@
// A mark or invalid request is held in the queue and then in the result register, which shows
// its single result; an allocate, a refusal for a busy start included, passes the queue, the
// walk load and the result register. An allocate holds the walk unit until its last result
// (up to 64). Results leave one per cycle while out_tready is high.
// Reset (rst_n low, synchronous) empties the queue; a clearing pass then frees one block per
// cycle, all BLOCK_COUNT blocks (64 by default), before the first request is taken.
module disk_block_run_allocator
  import drba_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] start_block, [12:6] run_length, zero pad
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] block_index, [8:6] outcome, zero pad
  output logic        out_tlast
);

  req_t                 front_req;
  req_t                 q_req;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic                 push;
  logic [START_W-1:0]   res_index;
  logic [OUTCOME_W-1:0] res_outcome;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;
  assign out_tdata = {7'b0, res_outcome, res_index};

  drba_front #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_front (
    .op    (in_tuser),
    .start (in_tdata[5:0]),
    .len   (in_tdata[12:6]),
    .req   (front_req)
  );

  drba_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (front_req),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_req  (q_req)
  );

  drba_back #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_req       (q_req),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_index   (res_index),
    .out_outcome (res_outcome),
    .out_last    (out_tlast)
  );

endmodule
